// ===== hw/rtl/aep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aep_pkg
// Shared types, codes and the control program of the allpass peak equaliser.
// ----------------------------------------------------------------------------
package aep_pkg;

   localparam int CSR_WIDTH = 32;
   localparam int STEP_W    = 4;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_BAND   = 2'd0;
   localparam csr_index_type CSR_CENTER = 2'd1;
   localparam csr_index_type CSR_GAIN   = 2'd2;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [3:0] {
      SRC_X,
      SRC_D1,
      SRC_D2,
      SRC_BAND,
      SRC_CENTER,
      SRC_OMC,
      SRC_NEGC,
      SRC_HALFH,
      SRC_T0,
      SRC_T1,
      SRC_T2,
      SRC_T3
   } src_type;

   typedef enum logic [2:0] {
      DST_T0,
      DST_T1,
      DST_T2,
      DST_T3,
      DST_OUT
   } dst_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_REQ,
      COND_RSP
   } cond_type;

   typedef struct packed {
      src_type    mul_a;
      src_type    mul_b;
      dst_type    mul_dst;
      logic       mul_en;
      alu_op_type alu_op;
      src_type    alu_a;
      src_type    alu_b;
      dst_type    alu_dst;
      logic       alu_en;
      cond_type   cond;
      logic       last;
      logic       jump;
      step_type   target;
   } ucode_word_type;

   typedef struct packed {
      ucode_word_type word;
      logic           adv;
      logic           load_x;
      logic           deliver;
      logic           commit;
      logic           take_slot;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_free;
   } status_type;

   localparam ucode_word_type UCODE_NOP = '{
      mul_a:   SRC_X,
      mul_b:   SRC_X,
      mul_dst: DST_T0,
      mul_en:  1'b0,
      alu_op:  ALU_ADD,
      alu_a:   SRC_X,
      alu_b:   SRC_X,
      alu_dst: DST_T0,
      alu_en:  1'b0,
      cond:    COND_NONE,
      last:    1'b0,
      jump:    1'b0,
      target:  '0
   };

   // One multiply and one saturating add/sub may issue per step.
   // T2 holds xh0 once step three has written it; the delay line takes it at the end.
   function automatic ucode_word_type ucode_fetch(input step_type step);
      ucode_word_type w;
      w = UCODE_NOP;
      unique case (step)
         4'd0: begin
            w.mul_en = 1'b1; w.mul_a = SRC_BAND; w.mul_b = SRC_D2; w.mul_dst = DST_T2;
            w.cond = COND_REQ;
         end
         4'd1: begin
            w.mul_en = 1'b1; w.mul_a = SRC_CENTER; w.mul_b = SRC_OMC; w.mul_dst = DST_T0;
            w.alu_en = 1'b1; w.alu_op = ALU_ADD; w.alu_a = SRC_X; w.alu_b = SRC_T2;
            w.alu_dst = DST_T2;
         end
         4'd2: begin
            w.mul_en = 1'b1; w.mul_a = SRC_T0; w.mul_b = SRC_D1; w.mul_dst = DST_T1;
         end
         4'd3: begin
            w.alu_en = 1'b1; w.alu_op = ALU_SUB; w.alu_a = SRC_T2; w.alu_b = SRC_T1;
            w.alu_dst = DST_T2;
         end
         4'd4: begin
            w.mul_en = 1'b1; w.mul_a = SRC_NEGC; w.mul_b = SRC_T2; w.mul_dst = DST_T3;
         end
         4'd5: begin
            w.alu_en = 1'b1; w.alu_op = ALU_ADD; w.alu_a = SRC_T3; w.alu_b = SRC_T1;
            w.alu_dst = DST_T3;
         end
         4'd6: begin
            w.alu_en = 1'b1; w.alu_op = ALU_ADD; w.alu_a = SRC_T3; w.alu_b = SRC_D2;
            w.alu_dst = DST_T3;
         end
         4'd7: begin
            w.alu_en = 1'b1; w.alu_op = ALU_SUB; w.alu_a = SRC_X; w.alu_b = SRC_T3;
            w.alu_dst = DST_T3;
         end
         4'd8: begin
            w.mul_en = 1'b1; w.mul_a = SRC_HALFH; w.mul_b = SRC_T3; w.mul_dst = DST_T3;
         end
         4'd9: begin
            w.alu_en = 1'b1; w.alu_op = ALU_ADD; w.alu_a = SRC_T3; w.alu_b = SRC_X;
            w.alu_dst = DST_OUT;
            w.cond = COND_RSP; w.last = 1'b1; w.jump = 1'b1; w.target = 4'd0;
         end
         default: begin
            w.jump = 1'b1; w.target = 4'd0;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/allpass_peak_eq_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// allpass_peak_eq_filter
// Second-order allpass peak equaliser on signed fixed-point audio samples.
// ----------------------------------------------------------------------------
// One sample beat in, one filtered sample beat out. A short control program
// steps a datapath holding one shared multiplier and one saturating adder;
// the program has ten steps and works on one sample at a time; its result
// lands in the output register on the last step, at the end of the
// dependent multiply/add chain through that one multiplier.
// Once the result is registered the program returns to its first
// step and takes the next sample while the previous result may still wait
// for the sink; should a second result be ready before the first is taken,
// the last step holds until the output register frees. Coefficients c, d and
// h0 sit in three write-only registers (index 0, 1, 2; other indices drop)
// and must be written between samples. Every product is floored after the
// fraction shift and every intermediate clamps to the sample range.
// ----------------------------------------------------------------------------
module allpass_peak_eq_filter #(
   parameter int FRAC_BITS    = 15,
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // sample input channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out,
   // coefficient write port
   input  wire logic                           csr_write_enable,
   input  wire aep_pkg::csr_index_type         csr_index,
   input  wire logic [aep_pkg::CSR_WIDTH-1:0]  csr_write_data
);
   import aep_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // The output register is free when empty or when its beat goes this cycle
   always_comb begin
      status.req_valid = req_valid;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   aep_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   aep_datapath #(
      .FRAC_BITS    (FRAC_BITS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sample_in        (req_sample_in),
      .sample_out       (rsp_sample_out)
   );

   // Take a sample only on the program's first step, never during reset
   assign req_stall = reset || !ctrl.take_slot;

   // Hold the result beat until taken; a new one lands only in a free slot
   always_comb begin
      priority if (ctrl.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/aep_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aep_sequencer
// Step counter and program table; waits on the two handshake conditions.
// ----------------------------------------------------------------------------
module aep_sequencer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire aep_pkg::status_type status,
   output aep_pkg::ctrl_type     ctrl
);
   import aep_pkg::*;

   step_type       step_ff;
   step_type       step_in;
   ucode_word_type word;
   logic           hold;

   assign word = ucode_fetch(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_REQ: hold = !status.req_valid;
         COND_RSP: hold = !status.rsp_free;
         default:  hold = 1'b0;
      endcase
   end

   always_comb begin
      priority if (hold) begin
         step_in = step_ff;
      end else if (word.jump) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      ctrl.word      = word;
      ctrl.adv       = !hold;
      ctrl.take_slot = (word.cond == COND_REQ);
      ctrl.load_x    = !hold && (word.cond == COND_REQ);
      ctrl.deliver   = !hold && (word.cond == COND_RSP);
      ctrl.commit    = !hold && word.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/aep_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aep_datapath
// Coefficient registers, working registers, one multiplier and one adder.
// ----------------------------------------------------------------------------
module aep_datapath #(
   parameter int FRAC_BITS    = 15,
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire aep_pkg::ctrl_type              ctrl,
   input  wire logic                           csr_write_enable,
   input  wire aep_pkg::csr_index_type         csr_index,
   input  wire logic [aep_pkg::CSR_WIDTH-1:0]  csr_write_data,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
   import aep_pkg::*;

   localparam int SW  = SAMPLE_WIDTH;
   localparam int OPW = (SW > CSR_WIDTH) ? SW : CSR_WIDTH;
   localparam int PW  = 2 * OPW;

   localparam logic signed [PW-1:0] SMAX_P = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [PW-1:0] SMIN_P = ~SMAX_P;
   localparam logic signed [PW-1:0] ONE_Q  = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic signed [CSR_WIDTH-1:0] band_ff,   band_in;
   logic signed [CSR_WIDTH-1:0] center_ff, center_in;
   logic signed [CSR_WIDTH-1:0] gain_ff,   gain_in;
   logic signed [SW-1:0]        omc_ff,    omc_in;
   logic signed [SW-1:0]        negc_ff,   negc_in;
   logic signed [SW-1:0]        halfh_ff,  halfh_in;
   logic signed [SW-1:0]        x_ff,      x_in;
   logic signed [SW-1:0]        d1_ff,     d1_in;
   logic signed [SW-1:0]        d2_ff,     d2_in;
   logic signed [SW-1:0]        tmp0_ff,   tmp0_in;
   logic signed [SW-1:0]        tmp1_ff,   tmp1_in;
   logic signed [SW-1:0]        tmp2_ff,   tmp2_in;
   logic signed [SW-1:0]        tmp3_ff,   tmp3_in;
   logic signed [SW-1:0]        out_ff,    out_in;

   logic signed [OPW-1:0] mul_a, mul_b, alu_a, alu_b;
   logic signed [PW-1:0]  mul_prod, mul_shift, alu_sum;
   logic signed [SW-1:0]  mul_res, alu_res;
   logic                  mul_we, alu_we;

   function automatic logic signed [SW-1:0] sat_to_sample(input logic signed [PW-1:0] v);
      logic signed [SW-1:0] r;
      priority if (v > SMAX_P) begin
         r = SMAX_P[SW-1:0];
      end else if (v < SMIN_P) begin
         r = SMIN_P[SW-1:0];
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [OPW-1:0] pick(input src_type s);
      logic signed [OPW-1:0] r;
      unique case (s)
         SRC_X:      r = OPW'(x_ff);
         SRC_D1:     r = OPW'(d1_ff);
         SRC_D2:     r = OPW'(d2_ff);
         SRC_BAND:   r = OPW'(band_ff);
         SRC_CENTER: r = OPW'(center_ff);
         SRC_OMC:    r = OPW'(omc_ff);
         SRC_NEGC:   r = OPW'(negc_ff);
         SRC_HALFH:  r = OPW'(halfh_ff);
         SRC_T0:     r = OPW'(tmp0_ff);
         SRC_T1:     r = OPW'(tmp1_ff);
         SRC_T2:     r = OPW'(tmp2_ff);
         SRC_T3:     r = OPW'(tmp3_ff);
         default:    r = '0;
      endcase
      return r;
   endfunction

   // Coefficient registers
   always_comb begin
      band_in   = band_ff;
      center_in = center_ff;
      gain_in   = gain_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BAND:   band_in   = csr_write_data;
            CSR_CENTER: center_in = csr_write_data;
            CSR_GAIN:   gain_in   = csr_write_data;
            default:    ;
         endcase
      end
   end

   // Terms that follow from the coefficients alone: 1 - c, -c and h0 / 2 (floor)
   always_comb begin
      omc_in   = sat_to_sample(ONE_Q - PW'(band_ff));
      negc_in  = sat_to_sample(-PW'(band_ff));
      halfh_in = sat_to_sample(PW'(gain_ff) >>> 1);
   end

   // Shared multiplier: exact product, floor shift, clamp
   always_comb begin
      mul_a     = pick(ctrl.word.mul_a);
      mul_b     = pick(ctrl.word.mul_b);
      mul_prod  = PW'(mul_a) * PW'(mul_b);
      mul_shift = mul_prod >>> FRAC_BITS;
      mul_res   = sat_to_sample(mul_shift);
   end

   // Saturating adder
   always_comb begin
      alu_a = pick(ctrl.word.alu_a);
      alu_b = pick(ctrl.word.alu_b);
      unique case (ctrl.word.alu_op)
         ALU_ADD: alu_sum = PW'(alu_a) + PW'(alu_b);
         ALU_SUB: alu_sum = PW'(alu_a) - PW'(alu_b);
         default: alu_sum = '0;
      endcase
      alu_res = sat_to_sample(alu_sum);
   end

   assign mul_we = ctrl.adv && ctrl.word.mul_en;
   assign alu_we = ctrl.adv && ctrl.word.alu_en;

   always_comb begin
      tmp0_in = tmp0_ff;
      tmp1_in = tmp1_ff;
      tmp2_in = tmp2_ff;
      tmp3_in = tmp3_ff;
      out_in  = out_ff;
      if (mul_we) begin
         unique case (ctrl.word.mul_dst)
            DST_T0:  tmp0_in = mul_res;
            DST_T1:  tmp1_in = mul_res;
            DST_T2:  tmp2_in = mul_res;
            DST_T3:  tmp3_in = mul_res;
            default: out_in  = mul_res;
         endcase
      end
      if (alu_we) begin
         unique case (ctrl.word.alu_dst)
            DST_T0:  tmp0_in = alu_res;
            DST_T1:  tmp1_in = alu_res;
            DST_T2:  tmp2_in = alu_res;
            DST_T3:  tmp3_in = alu_res;
            default: out_in  = alu_res;
         endcase
      end
   end

   always_comb begin
      x_in  = ctrl.load_x ? sample_in : x_ff;
      // Advance the delay line; T2 carries xh0 at the end of the program
      d1_in = ctrl.commit ? tmp2_ff : d1_ff;
      d2_in = ctrl.commit ? d1_ff : d2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff   <= '0;
         center_ff <= '0;
         gain_ff   <= '0;
         d1_ff     <= '0;
         d2_ff     <= '0;
      end else begin
         band_ff   <= band_in;
         center_ff <= center_in;
         gain_ff   <= gain_in;
         d1_ff     <= d1_in;
         d2_ff     <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      omc_ff   <= omc_in;
      negc_ff  <= negc_in;
      halfh_ff <= halfh_in;
      x_ff     <= x_in;
      tmp0_ff  <= tmp0_in;
      tmp1_ff  <= tmp1_in;
      tmp2_ff  <= tmp2_in;
      tmp3_ff  <= tmp3_in;
      out_ff   <= out_in;
   end

   assign sample_out = out_ff;

endmodule
`default_nettype wire
